[hdl/cqe_pkg.sv]
package cqe_pkg;
  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int POS_W = 7;
  localparam int STATUS_W = 3;

  localparam logic [MODE_W-1:0] MODE_ENQ = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SWAP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INS = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REV = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FEW = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0] occupancy;
  } res_t;
endpackage

[hdl/cqe_cmd_if.sv]
interface cqe_cmd_if;
  logic valid;
  logic ready;
  cqe_pkg::cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/cqe_res_if.sv]
interface cqe_res_if;
  logic valid;
  logic ready;
  cqe_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/cqe_ram.sv]
module cqe_ram #(
  parameter int DEPTH = cqe_pkg::DEPTH_DEFAULT,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [cqe_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [cqe_pkg::DATA_W-1:0] rdata
);
  logic [cqe_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/circular_queue_engine_unit.sv]
// channel | way | fields
// cmd     | in  | mode[2:0] value[31:0] position[6:0]
// res     | out | data[31:0] status[2:0] occupancy[6:0]
// One request at a time; the RAM read is registered, one access per step.
// Errors and unknown modes go straight to the result; enqueue writes one slot,
// dequeue reads one, swap exchanges first and last, maximum reads all n, insert
// shifts p..n-1 up, reverse swaps the first p pairwise; n = occupancy, p = position.
// rst is synchronous; head pointer and count clear, tail pointer goes to DEPTH-1, RAM contents are left as is.
// The result waits in its register until taken;
// no new request meanwhile.
module circular_queue_engine_unit #(
  parameter int DEPTH = cqe_pkg::DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  cqe_cmd_if.sink cmd,
  cqe_res_if.source res
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_A = 3'd2;
  localparam logic [2:0] S_B = 3'd3;
  localparam logic [2:0] S_C = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [AW-1:0] head_ptr, tail_ptr;
  logic [CW-1:0] fill_count;
  cqe_pkg::cmd_t c;
  cqe_pkg::res_t r;
  logic [CW-1:0] lo, hi;
  logic [cqe_pkg::DATA_W-1:0] tmp;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [cqe_pkg::DATA_W-1:0] wdata, rdata;

  logic [CW-1:0] pos_c;
  logic in_pos_big;
  logic in_pos_zero;
  logic in_pos_one;
  logic [cqe_pkg::STATUS_W-1:0] acc_status;
  logic acc_go;
  logic [CW-1:0] acc_hi;

  cqe_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(o);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign pos_c = CW'(c.position);
  assign in_pos_big = 32'(cmd.payload.position) > 32'(fill_count);
  assign in_pos_zero = (cmd.payload.position == '0);
  assign in_pos_one = (cmd.payload.position == cqe_pkg::POS_W'(1));

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign res.payload = r;

  // request decode at acceptance
  always_comb begin
    acc_status = cqe_pkg::ST_OK;
    acc_go = 1'b0;
    acc_hi = fill_count;
    unique case (cmd.payload.mode)
      cqe_pkg::MODE_ENQ: begin
        if (fill_count >= DEPTH_C) acc_status = cqe_pkg::ST_FULL;
        else acc_go = 1'b1;
      end
      cqe_pkg::MODE_DEQ, cqe_pkg::MODE_MAX: begin
        if (fill_count == '0) acc_status = cqe_pkg::ST_EMPTY;
        else acc_go = 1'b1;
      end
      cqe_pkg::MODE_SWAP: begin
        acc_hi = fill_count - CW'(1);
        if (fill_count < CW'(2)) acc_status = cqe_pkg::ST_FEW;
        else acc_go = 1'b1;
      end
      cqe_pkg::MODE_INS: begin
        if (fill_count >= DEPTH_C) acc_status = cqe_pkg::ST_FULL;
        else if (in_pos_big) acc_status = cqe_pkg::ST_BADPOS;
        else acc_go = 1'b1;
      end
      cqe_pkg::MODE_REV: begin
        acc_hi = CW'(cmd.payload.position) - CW'(1);
        if (in_pos_zero || in_pos_big) acc_status = cqe_pkg::ST_BADPOS;
        else acc_go = !in_pos_one;
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_IDLE: ;
      S_RD: begin
        if (c.mode == cqe_pkg::MODE_ENQ) begin
          we = 1'b1;
          waddr = slot(tail_ptr, CW'(1));
          wdata = c.value;
        end else if (c.mode == cqe_pkg::MODE_INS) begin
          if (hi == pos_c) begin
            we = 1'b1;
            waddr = slot(head_ptr, hi);
            wdata = c.value;
          end else raddr = slot(head_ptr, hi - CW'(1));
        end else raddr = slot(head_ptr, lo);
      end
      S_A: begin
        if (c.mode == cqe_pkg::MODE_INS) begin
          we = 1'b1;
          waddr = slot(head_ptr, hi);
          wdata = rdata;
        end else raddr = slot(head_ptr, hi);
      end
      S_B: begin
        we = 1'b1;
        waddr = slot(head_ptr, lo);
        wdata = rdata;
      end
      S_C: begin
        we = 1'b1;
        waddr = slot(head_ptr, hi);
        wdata = tmp;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head_ptr <= '0;
      tail_ptr <= AW'(DEPTH - 1);
      fill_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd.valid) begin
          c <= cmd.payload;
          r.data <= '0;
          r.status <= acc_status;
          r.occupancy <= cqe_pkg::POS_W'(fill_count);
          lo <= '0;
          hi <= acc_hi;
          state <= acc_go ? S_RD : S_OUT;
        end
        S_RD: begin
          case (c.mode)
            cqe_pkg::MODE_ENQ: begin
              tail_ptr <= slot(tail_ptr, CW'(1));
              fill_count <= fill_count + CW'(1);
              r.occupancy <= cqe_pkg::POS_W'(fill_count + CW'(1));
              state <= S_OUT;
            end
            cqe_pkg::MODE_INS:
              if (hi == pos_c) begin
                tail_ptr <= slot(tail_ptr, CW'(1));
                fill_count <= fill_count + CW'(1);
                r.occupancy <= cqe_pkg::POS_W'(fill_count + CW'(1));
                state <= S_OUT;
              end else state <= S_A;
            default: state <= S_A;
          endcase
        end
        S_A: begin
          case (c.mode)
            cqe_pkg::MODE_DEQ: begin
              r.data <= rdata;
              head_ptr <= slot(head_ptr, CW'(1));
              fill_count <= fill_count - CW'(1);
              r.occupancy <= cqe_pkg::POS_W'(fill_count - CW'(1));
              state <= S_OUT;
            end
            cqe_pkg::MODE_MAX: begin
              if (lo == '0 || $signed(rdata) > $signed(r.data)) r.data <= rdata;
              if (lo + CW'(1) >= fill_count) state <= S_OUT;
              else begin
                lo <= lo + CW'(1);
                state <= S_RD;
              end
            end
            cqe_pkg::MODE_INS: begin
              hi <= hi - CW'(1);
              state <= S_RD;
            end
            default: begin
              tmp <= rdata;
              state <= S_B;
            end
          endcase
        end
        S_B: state <= S_C;
        S_C: begin
          lo <= lo + CW'(1);
          hi <= hi - CW'(1);
          if (c.mode == cqe_pkg::MODE_SWAP || lo + CW'(2) >= hi) state <= S_OUT;
          else state <= S_RD;
        end
        S_OUT: if (res.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill_count <= DEPTH_C)
    else $error("occupancy overflow");
  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.payload))
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !res.valid)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.payload.status <= cqe_pkg::ST_FEW)
    else $error("bad status code");
endmodule
